// File: rtl/ccse_pkg.sv
package ccse_pkg;

  localparam int DW = 32;
  localparam int CW = 40;
  localparam int TW = 17;
  localparam int PW = CW + TW + 1;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int BACK_STAGES = 8;

  localparam logic [TW-1:0] T_ONE = 17'h10000;
  localparam logic signed [CW-1:0] SIX_LIMIT = 40'sd12884901888;
  localparam logic [19:0] DIV3_RECIP = 20'd699050;
  localparam logic [DW-1:0] SAT_MAX = 32'h7fffffff;
  localparam logic [DW-1:0] SAT_MIN = 32'h80000000;

  typedef enum logic [2:0] {
    KIND_BSPLINE = 3'd0,
    KIND_HERMITE = 3'd1,
    KIND_BEZIER  = 3'd2,
    KIND_CATMULL = 3'd3,
    KIND_LINEAR  = 3'd4
  } curve_kind_t;

  typedef struct packed {
    logic bspline;
    logic catmull;
    logic linear;
  } kind_flags_t;

  typedef struct packed {
    logic div6;
    logic half;
    logic zero;
  } scale_mode_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] a3;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
    logic [TW-1:0]        t;
    kind_flags_t          flags;
  } seg_t;

  function automatic logic signed [PW-1:0] mul_t(input logic signed [CW-1:0] x,
                                                  input logic [TW-1:0] t);
    logic signed [PW-1:0] p;
    p = PW'(x) * PW'($signed({1'b0, t}));
    return p;
  endfunction

  // floor((p + 0.5 lsb) / 2^16)
  function automatic logic signed [CW-1:0] rnd16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + PW'(32768);
    return s[CW+15:16];
  endfunction

  // {quotient, remainder} of x / 3
  function automatic logic [20:0] div3(input logic [19:0] x);
    logic [39:0] p;
    logic [18:0] q;
    logic [19:0] r;
    p = 40'(x) * 40'(DIV3_RECIP);
    q = p[39:21];
    r = x - (20'(q) * 20'd3);
    if (r >= 20'd3) begin
      q = q + 19'd1;
      r = r - 20'd3;
    end
    return {q, r[1:0]};
  endfunction

  function automatic logic [DW-1:0] sat32(input logic signed [CW-1:0] x);
    if (x > 40'sd2147483647) begin
      return SAT_MAX;
    end else if (x < -40'sd2147483648) begin
      return SAT_MIN;
    end else begin
      return x[DW-1:0];
    end
  endfunction

endpackage

// File: rtl/ccse_front.sv
module ccse_front import ccse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           kind,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] p0,
  input  logic signed [DW-1:0] p1,
  input  logic signed [DW-1:0] p2,
  input  logic signed [DW-1:0] p3,
  input  logic [TW-1:0]        t,
  output logic                 seg_valid,
  input  logic                 seg_ready,
  output seg_t                 seg
);

  seg_t seg_next;
  logic signed [CW-1:0] x, y, z, w, ac;

  assign x = CW'(p0);
  assign y = CW'(p1);
  assign z = CW'(p2);
  assign w = CW'(p3);

  always_comb begin
    seg_next = '0;
    ac = -x + 3 * y - 3 * z + w;
    seg_next.t = (t > T_ONE) ? T_ONE : t;
    case (kind)
      KIND_BSPLINE: begin
        seg_next.a = ac;
        seg_next.b = 3 * x - 6 * y + 3 * z;
        seg_next.c = -3 * x + 3 * z;
        seg_next.d = x + 4 * y + z;
        seg_next.flags.bspline = 1'b1;
      end
      KIND_HERMITE: begin
        seg_next.a = 2 * x - 2 * y + z + w;
        seg_next.b = -3 * x + 3 * y - 2 * z - w;
        seg_next.c = z;
        seg_next.d = x;
      end
      KIND_BEZIER: begin
        seg_next.a = ac;
        seg_next.b = 3 * x - 6 * y + 3 * z;
        seg_next.c = -3 * x + 3 * y;
        seg_next.d = x;
      end
      KIND_CATMULL: begin
        seg_next.a = ac;
        seg_next.b = 2 * x - 5 * y + 4 * z - w;
        seg_next.c = z - x;
        seg_next.d = 2 * y;
        seg_next.flags.catmull = 1'b1;
      end
      default: begin
        // linear, also the unused codes
        seg_next.a = '0;
        seg_next.b = '0;
        seg_next.c = y - x;
        seg_next.d = x;
        seg_next.flags.linear = 1'b1;
      end
    endcase
    seg_next.a3 = seg_next.a + (seg_next.a <<< 1);
  end

  assign in_ready = !seg_valid || seg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (in_ready) begin
      seg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg <= seg_next;
    end
  end

endmodule

// File: rtl/ccse_queue.sv
module ccse_queue import ccse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  seg_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output seg_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  seg_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic push, pop;

  assign in_ready  = count != CNTW'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// File: rtl/ccse_scale.sv
module ccse_scale import ccse_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x,
  input  scale_mode_t          mode,
  output logic [DW-1:0]        y
);

  logic signed [CW-1:0] yv, yo, dir_next, dir;
  logic ovf_next, unf_next, ovf, unf, use_div;
  logic [20:0] qh_full, ql_full;
  logic [14:0] qh;
  logic [1:0]  rh;
  logic [16:0] lo;
  logic [DW-1:0] quot, res, y_next;

  // divide by six: bias into range, halve, then two narrow divides by three
  always_comb begin
    yv = x + CW'(3);
    yo = yv + SIX_LIMIT;
    ovf_next = yv >= SIX_LIMIT;
    unf_next = yv < -SIX_LIMIT;
    qh_full = div3({3'b000, yo[34:18]});
    if (mode.zero) begin
      dir_next = '0;
    end else if (mode.half) begin
      dir_next = (x + CW'(1)) >>> 1;
    end else begin
      dir_next = x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      use_div <= mode.div6;
      ovf     <= ovf_next;
      unf     <= unf_next;
      qh      <= qh_full[16:2];
      rh      <= qh_full[1:0];
      lo      <= yo[17:1];
      dir     <= dir_next;
    end
  end

  always_comb begin
    ql_full = div3({1'b0, rh, lo});
    quot = {qh, ql_full[18:2]};
    if (ovf) begin
      res = SAT_MAX;
    end else if (unf) begin
      res = SAT_MIN;
    end else begin
      res = {~quot[DW-1], quot[DW-2:0]};
    end
    y_next = use_div ? res : sat32(dir);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
    end
  end

endmodule

// File: rtl/ccse_back.sv
module ccse_back import ccse_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          seg_valid,
  output logic          seg_ready,
  input  seg_t          seg,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] value,
  output logic [DW-1:0] slope
);

  logic [BACK_STAGES-1:0] vld;
  logic en;

  logic signed [PW-1:0] pa1, p3a1, ps3, pu3, ps5;
  logic signed [CW-1:0] b1, c1, d1, s2, u2, c2, d2, c3, d3, v4, sl4, d4, sl5, d5, v6, sl6;
  logic [TW-1:0] t1, t2, t3, t4;
  kind_flags_t f1, f2, f3, f4, f5, f6;
  scale_mode_t vmode, smode;

  // whole pipeline holds while the output request waits
  assign en = !(vld[BACK_STAGES-1] && !out_ready);
  assign seg_ready = en;
  assign out_valid = vld[BACK_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_STAGES-2:0], seg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1  <= mul_t(seg.a, seg.t);
      p3a1 <= mul_t(seg.a3, seg.t);
      b1   <= seg.b;
      c1   <= seg.c;
      d1   <= seg.d;
      t1   <= seg.t;
      f1   <= seg.flags;

      s2 <= b1 + rnd16(pa1);
      u2 <= (b1 <<< 1) + rnd16(p3a1);
      c2 <= c1;
      d2 <= d1;
      t2 <= t1;
      f2 <= f1;

      ps3 <= mul_t(s2, t2);
      pu3 <= mul_t(u2, t2);
      c3  <= c2;
      d3  <= d2;
      t3  <= t2;
      f3  <= f2;

      v4  <= c3 + rnd16(ps3);
      sl4 <= c3 + rnd16(pu3);
      d4  <= d3;
      t4  <= t3;
      f4  <= f3;

      ps5 <= mul_t(v4, t4);
      sl5 <= sl4;
      d5  <= d4;
      f5  <= f4;

      v6  <= d5 + rnd16(ps5);
      sl6 <= sl5;
      f6  <= f5;
    end
  end

  always_comb begin
    vmode.div6 = f6.bspline;
    vmode.half = f6.catmull;
    vmode.zero = 1'b0;
    smode.div6 = f6.bspline;
    smode.half = 1'b0;
    smode.zero = f6.linear;
  end

  ccse_scale u_scale_value (
    .clk  (clk),
    .en   (en),
    .x    (v6),
    .mode (vmode),
    .y    (value)
  );

  ccse_scale u_scale_slope (
    .clk  (clk),
    .en   (en),
    .x    (sl6),
    .mode (smode),
    .y    (slope)
  );

endmodule

// File: rtl/cubic_curve_segment_evaluator_core.sv
// Channel   Valid      Ready      Payload
// input     in_valid   in_ready   p0, p1, p2, p3, t
// output    out_valid  out_ready  value, slope
// config    psel       pready     penable, pwrite, paddr, pwdata, prdata
//
// One request per cycle sustained while out_ready stays high; out_valid rises
// after the accepting edge has passed the front register, the queue, six Horner
// stages and two scaling stages ending in the output register.
// rst is synchronous; it clears curve_kind, the queue and all valid bits.
// A stalled output holds the back pipeline; the front keeps taking requests
// until the queue fills, so in_ready does not follow out_ready.
module cubic_curve_segment_evaluator_core import ccse_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] p0,
  input  logic signed [DW-1:0] p1,
  input  logic signed [DW-1:0] p2,
  input  logic signed [DW-1:0] p3,
  input  logic [TW-1:0]        t,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] value,
  output logic signed [DW-1:0] slope
);

  localparam logic REG_CURVE_KIND = 1'b0;

  logic [2:0] curve_kind;
  logic f_valid, f_ready, q_valid, q_ready;
  seg_t f_seg, q_seg;
  logic [DW-1:0] value_u, slope_u;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CURVE_KIND) ? {29'd0, curve_kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind <= KIND_BSPLINE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CURVE_KIND) begin
      curve_kind <= pwdata[2:0];
    end
  end

  ccse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .kind      (curve_kind),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .p0        (p0),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3),
    .t         (t),
    .seg_valid (f_valid),
    .seg_ready (f_ready),
    .seg       (f_seg)
  );

  ccse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_seg),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_seg)
  );

  ccse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (q_valid),
    .seg_ready (q_ready),
    .seg       (q_seg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value_u),
    .slope     (slope_u)
  );

  assign value = $signed(value_u);
  assign slope = $signed(slope_u);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(q_valid && q_ready))
    else $error("queue popped while output stalled");

  a_accept_reaches_front: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> f_valid)
    else $error("accepted request lost at front");

endmodule

// File: sim/tb_cubic_curve_segment_evaluator_core.sv
`timescale 1ns / 1ps

module tb_cubic_curve_segment_evaluator_core;
  import ccse_pkg::*;

  localparam logic [2:0] KIND_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  // kinds 5..7 have no curve of their own and fall back to linear
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam int N_PHASES   = 10;
  localparam int PHASE_REQS = 55;
  localparam int DRAIN_GAP  = 20;

  typedef struct {
    logic signed [DW-1:0] value;
    logic signed [DW-1:0] slope;
  } curve_point_t;

  class curve_scoreboard;
    logic [2:0]   kind = KIND_BSPLINE;
    curve_point_t pending_pts[$];
    int           errors = 0;
    int           checked = 0;
    int           requests = 0;

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function longint round_q16(input longint x);
      return (x + 32768) >>> 16;
    endfunction

    function longint div_six(input longint x);
      longint n;
      n = x + 3;
      if (n < 0) begin
        return -((-n + 5) / 6);
      end
      return n / 6;
    endfunction

    function logic [DW-1:0] clamp32(input longint x);
      if (x > 64'sd2147483647) begin
        return SAT_MAX;
      end else if (x < -64'sd2147483648) begin
        return SAT_MIN;
      end
      return x[DW-1:0];
    endfunction

    function void note_request(input logic signed [DW-1:0] q0, q1, q2, q3,
                               input logic [TW-1:0] tr);
      longint x, y, z, w, tt, a, b, c, d, v, s;
      curve_point_t pt;
      x = q0;
      y = q1;
      z = q2;
      w = q3;
      tt = (tr > T_ONE) ? longint'(T_ONE) : longint'(tr);
      requests++;
      case (kind)
        KIND_BSPLINE: begin
          a = -x + 3 * y - 3 * z + w;
          b = 3 * x - 6 * y + 3 * z;
          c = -3 * x + 3 * z;
          d = x + 4 * y + z;
        end
        KIND_HERMITE: begin
          a = 2 * x - 2 * y + z + w;
          b = -3 * x + 3 * y - 2 * z - w;
          c = z;
          d = x;
        end
        KIND_BEZIER: begin
          a = -x + 3 * y - 3 * z + w;
          b = 3 * x - 6 * y + 3 * z;
          c = -3 * x + 3 * y;
          d = x;
        end
        KIND_CATMULL: begin
          a = -x + 3 * y - 3 * z + w;
          b = 2 * x - 5 * y + 4 * z - w;
          c = z - x;
          d = 2 * y;
        end
        default: begin
          pt.value = clamp32(x + round_q16((y - x) * tt));
          pt.slope = '0;
          pending_pts.push_back(pt);
          return;
        end
      endcase
      v = b + round_q16(a * tt);
      v = c + round_q16(v * tt);
      v = d + round_q16(v * tt);
      s = 2 * b + round_q16(3 * a * tt);
      s = c + round_q16(s * tt);
      if (kind == KIND_BSPLINE) begin
        v = div_six(v);
        s = div_six(s);
      end else if (kind == KIND_CATMULL) begin
        v = (v + 1) >>> 1;
      end
      pt.value = clamp32(v);
      pt.slope = clamp32(s);
      pending_pts.push_back(pt);
    endfunction

    task check_result(input logic signed [DW-1:0] got_value, got_slope);
      curve_point_t pt;
      if (pending_pts.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h slope=%h",
                                  got_value, got_slope));
        return;
      end
      pt = pending_pts.pop_front();
      if (got_value !== pt.value) begin
        report_mismatch($sformatf("result %0d value %h, want %h", checked,
                                  got_value, pt.value));
      end
      if (got_slope !== pt.slope) begin
        report_mismatch($sformatf("result %0d slope %h, want %h", checked,
                                  got_slope, pt.slope));
      end
      checked++;
    endtask

    task finish_check();
      if (pending_pts.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", pending_pts.size()));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] p0 = '0;
  logic signed [DW-1:0] p1 = '0;
  logic signed [DW-1:0] p2 = '0;
  logic signed [DW-1:0] p3 = '0;
  logic [TW-1:0]        t = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] value;
  logic signed [DW-1:0] slope;

  logic                 idle_on = 1'b1;
  int                   stall_left = 0;
  int                   kind_writes = 0;
  curve_scoreboard      sb = new();

  cubic_curve_segment_evaluator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .p0       (p0),
    .p1       (p1),
    .p2       (p2),
    .p3       (p3),
    .t        (t),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value),
    .slope    (slope)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(value, slope);
    end
  end

  // all tasks start and end at a falling edge with nothing yet driven there
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == KIND_ADDR) begin
      sb.kind = data[2:0];
      kind_writes++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_kind();
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= KIND_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {29'd0, sb.kind}) begin
      sb.report_mismatch($sformatf("curve_kind read %h, want %0d", prdata, sb.kind));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_segment(input logic signed [DW-1:0] q0, q1, q2, q3,
                              input logic [TW-1:0] tr);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    p0 <= q0;
    p1 <= q1;
    p2 <= q2;
    p3 <= q3;
    t <= tr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q0, q1, q2, q3, tr);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_pts.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_ctrl();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2, 3, 4: return r;
      default: return {{12{r[20]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return TW'($urandom_range(65537, 131071));
      default: return TW'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin : stim
    logic [2:0]  phase_kinds [N_PHASES];
    logic [31:0] rv;
    logic [2:0]  k;
    phase_kinds = '{KIND_HERMITE, KIND_CATMULL, KIND_SPARE_7, KIND_BEZIER, KIND_LINEAR,
                    KIND_SPARE_5, KIND_BSPLINE, KIND_SPARE_6, KIND_CATMULL, KIND_BSPLINE};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_kind();

    // directed: extremes, clamped t, rounding ties, every kind incl. the spare codes
    for (int i = 0; i < 8; i++) begin
      k = i[2:0];
      if (i > 0) begin
        drain();
        rv = $urandom();
        write_reg(KIND_ADDR, {rv[31:3], k});
        read_kind();
      end
      send_segment(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 17'h1ffff);
      send_segment(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, T_ONE);
      if (k[0]) begin
        send_segment(32'sh1, -32'sh1, 32'sh3, -32'sh3, 17'h08000);
      end else begin
        send_segment(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, '0);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      rv = $urandom();
      write_reg(KIND_ADDR, {rv[31:3], phase_kinds[ph]});
      if (ph == 2 || ph == 6) begin
        // writes to other addresses must leave the kind alone
        write_reg(SPARE_ADDR, $urandom());
      end
      read_kind();
      if (ph == N_PHASES - 1) begin
        idle_on = 1'b0;
      end
      repeat (PHASE_REQS) begin
        send_segment(rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_t());
      end
    end

    drain();
    sb.finish_check();
    $display("Sent %0d segments under %0d curve_kind writes; %0d results checked.",
             sb.requests, kind_writes, sb.checked);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Timeout: pipeline stopped making progress");
    $display("Mismatches found");
    $finish;
  end

endmodule
